// ===== rtl/gr_pkg.sv =====
// ----------------------------------------------------------------------------
// gr_pkg: shared types, constants and the sine table builder
// Holds the fixed-point constants of the column ray caster, the job and
// state types, and the elaboration-time sine table generator.
// ----------------------------------------------------------------------------
package gr_pkg;

  localparam int unsigned ScreenWidth  = 256;
  localparam int unsigned ScreenHeight = 128;
  localparam int unsigned MaxSteps     = 160;
  localparam int unsigned FovAngle     = 512;
  localparam int unsigned PosScale     = 640;
  localparam int unsigned CellUnits    = 163840;
  localparam int unsigned MapSize      = 16;

  localparam int unsigned AngW    = 12;
  localparam int unsigned DirW    = 16;
  localparam int unsigned PrW     = 24;
  localparam int unsigned StepW   = 8;
  localparam int unsigned NumW    = 16;
  localparam int unsigned DenW    = 10;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned SineDepth = 1025;
  localparam int unsigned SineW   = 15;
  localparam int unsigned SineIdxW = 11;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP0    = 3'd0,
    REG_MAP1    = 3'd1,
    REG_MAP2    = 3'd2,
    REG_MAP3    = 3'd3,
    REG_POS_X   = 3'd4,
    REG_POS_Y   = 3'd5,
    REG_HEADING = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SIN,
    F_COS,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MARCH,
    B_LOAD,
    B_DIV,
    B_DONE
  } back_state_e;

  // One column with its ray direction on its way to the marcher.
  typedef struct packed {
    logic [7:0]             column;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
  } job_t;

  typedef logic [SineW-1:0] sine_rom_t [SineDepth];

  // Taylor series to the ninth power in unsigned Q30, rounded to Q14.
  function automatic logic [SineW-1:0] quarter_sine(input longint unsigned a);
    longint unsigned th;
    longint unsigned t2;
    longint unsigned s;
    longint unsigned r;
    th = (a * 64'd3373259426) / 64'd2048;
    t2 = (th * th) >> 30;
    s  = 64'd1073741824 - (t2 / 64'd72);
    s  = 64'd1073741824 - (((t2 / 64'd42) * s) >> 30);
    s  = 64'd1073741824 - (((t2 / 64'd20) * s) >> 30);
    s  = 64'd1073741824 - (((t2 / 64'd6) * s) >> 30);
    s  = (th * s) >> 30;
    r  = (s + 64'd32768) >> 16;
    return r[SineW-1:0];
  endfunction

  function automatic sine_rom_t sine_table();
    sine_rom_t t;
    for (int i = 0; i < SineDepth; i++) begin
      t[i] = quarter_sine(longint'(i));
    end
    return t;
  endfunction

endpackage

// ===== rtl/gr_if.sv =====
// ----------------------------------------------------------------------------
// gr_if: column and result stream interfaces
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface gr_column_if;
  logic       valid;
  logic       ready;
  logic [7:0] column;

  modport source (output valid, output column, input ready);
  modport sink (input valid, input column, output ready);
endinterface

interface gr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_out;
  logic [7:0] distance_steps;
  logic       hit_wall;
  logic [6:0] ceiling_row;
  logic [7:0] floor_row;
  logic [3:0] wall_shade;

  modport source (output valid, output column_out, output distance_steps,
                  output hit_wall, output ceiling_row, output floor_row,
                  output wall_shade, input ready);
  modport sink (input valid, input column_out, input distance_steps,
                input hit_wall, input ceiling_row, input floor_row,
                input wall_shade, output ready);
endinterface

// ===== rtl/gr_front.sv =====
// ----------------------------------------------------------------------------
// gr_front: ray angle and direction lookup
// Forms the ray angle of a column and reads sine and cosine from the
// quarter-wave table, one read per cycle, then hands the job on.
// ----------------------------------------------------------------------------
module gr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gr_pkg::AngW-1:0]    heading_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_column_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output gr_pkg::job_t               job_o
);

  localparam gr_pkg::sine_rom_t SineRom = gr_pkg::sine_table();
  localparam int unsigned FovW = $clog2(gr_pkg::FovAngle) + 1;
  localparam int unsigned SwSh = $clog2(gr_pkg::ScreenWidth);

  gr_pkg::front_state_e state_q, state_d;

  logic [gr_pkg::AngW-1:0]     angle_q, angle_d;
  logic [gr_pkg::AngW-1:0]     look_ang;
  logic [gr_pkg::SineIdxW-1:0] rom_idx;
  logic [gr_pkg::SineW-1:0]    rom_q;
  logic                        neg_q;
  logic [7:0]                  column_q;
  logic signed [gr_pkg::DirW-1:0] dir_x_q;
  logic signed [gr_pkg::DirW-1:0] rom_val;
  logic [8+FovW-1:0]           col_prod;

  always_comb begin
    col_prod = {{FovW{1'b0}}, in_column_i} * (8+FovW)'(gr_pkg::FovAngle);
    angle_d  = heading_i + gr_pkg::AngW'(col_prod >> SwSh)
             - gr_pkg::AngW'(gr_pkg::FovAngle / 2);
  end

  // Cosine is the sine a quarter turn ahead.
  assign look_ang = (state_q == gr_pkg::F_COS) ? angle_q + 12'd1024 : angle_q;
  assign rom_idx  = look_ang[10] ? 11'd1024 - {1'b0, look_ang[9:0]}
                                 : {1'b0, look_ang[9:0]};
  assign rom_val  = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      gr_pkg::F_IDLE: if (in_valid_i) state_d = gr_pkg::F_SIN;
      gr_pkg::F_SIN:  state_d = gr_pkg::F_COS;
      gr_pkg::F_COS:  state_d = gr_pkg::F_PUSH;
      gr_pkg::F_PUSH: if (job_ready_i) state_d = gr_pkg::F_IDLE;
      default:        state_d = gr_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == gr_pkg::F_IDLE);
    job_valid_o  = (state_q == gr_pkg::F_PUSH);
    job_o.column = column_q;
    job_o.dir_x  = dir_x_q;
    job_o.dir_y  = rom_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gr_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && state_q == gr_pkg::F_IDLE) begin
      angle_q  <= angle_d;
      column_q <= in_column_i;
    end
    if (state_q == gr_pkg::F_SIN || state_q == gr_pkg::F_COS) begin
      rom_q <= SineRom[rom_idx];
      neg_q <= look_ang[11];
    end
    if (state_q == gr_pkg::F_COS) begin
      dir_x_q <= rom_val;
    end
  end

endmodule

// ===== rtl/gr_queue.sv =====
// ----------------------------------------------------------------------------
// gr_queue: two-entry job queue
// Decouples direction lookup from the marcher.
// ----------------------------------------------------------------------------
module gr_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  gr_pkg::job_t push_job_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output gr_pkg::job_t pop_job_o
);

  gr_pkg::job_t mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;
  logic         do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

// ===== rtl/gr_back.sv =====
// ----------------------------------------------------------------------------
// gr_back: ray marcher and result stage
// Steps the probe one tenth of a cell per cycle, then divides for the
// ceiling row bit by bit and registers the finished result.
// ----------------------------------------------------------------------------
module gr_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [255:0]            map_i,
  input  logic [11:0]             pos_x_i,
  input  logic [11:0]             pos_y_i,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  gr_pkg::job_t            job_i,
  gr_result_if.source             res_o
);

  localparam logic signed [gr_pkg::PrW-1:0] Limit =
    gr_pkg::PrW'(gr_pkg::MapSize * gr_pkg::CellUnits);
  localparam logic [gr_pkg::StepW-1:0] MaxN = gr_pkg::StepW'(gr_pkg::MaxSteps);

  gr_pkg::back_state_e state_q, state_d;

  logic signed [gr_pkg::PrW-1:0]  px_q, py_q, ex_q, ey_q;
  logic [gr_pkg::StepW-1:0]       n_q;
  logic                           hit_q;
  logic [7:0]                     col_q;
  logic [gr_pkg::DenW-1:0]        rem_q;
  logic [gr_pkg::NumW-1:0]        quo_q;
  logic [gr_pkg::DenW-1:0]        den_q;
  logic [gr_pkg::DivCntW-1:0]     cnt_q;
  logic [3:0]                     shade_q;

  logic                           outside, wall, march_end;
  logic [15:0]                    cx_prod, cy_prod;
  logic [3:0]                     cx, cy;
  logic [gr_pkg::DenW:0]          rem_sh;
  logic [gr_pkg::DenW:0]          rem_sub;
  logic [gr_pkg::NumW-1:0]        num;
  logic [3:0]                     shade_d;
  logic                           res_load;

  // The cell is px / 163840: shift by 2^15, then divide the small rest by 5.
  assign cx_prod = 16'({8'd0, px_q[22:15]} * 16'd205);
  assign cy_prod = 16'({8'd0, py_q[22:15]} * 16'd205);
  assign cx      = cx_prod[13:10];
  assign cy      = cy_prod[13:10];
  assign outside = px_q[gr_pkg::PrW-1] || py_q[gr_pkg::PrW-1]
                || (px_q >= Limit) || (py_q >= Limit);
  assign wall    = map_i[{cy, cx}];
  assign march_end = outside || wall || (n_q == MaxN);

  assign rem_sh  = {rem_q, quo_q[gr_pkg::NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    if (n_q > 8'd20) begin
      num = gr_pkg::NumW'(n_q * gr_pkg::ScreenHeight - 20 * gr_pkg::ScreenHeight);
    end else begin
      num = '0;
    end
  end

  always_comb begin
    shade_d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (k * int'(n_q) < gr_pkg::MaxSteps) shade_d = 4'(k);
    end
    if (10 * int'(n_q) <= gr_pkg::MaxSteps) shade_d = 4'd10;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gr_pkg::B_IDLE:  if (job_valid_i) state_d = gr_pkg::B_MARCH;
      gr_pkg::B_MARCH: if (march_end) state_d = gr_pkg::B_LOAD;
      gr_pkg::B_LOAD:  state_d = gr_pkg::B_DIV;
      gr_pkg::B_DIV:   if (cnt_q == '0) state_d = gr_pkg::B_DONE;
      gr_pkg::B_DONE:  if (res_load) state_d = gr_pkg::B_IDLE;
      default:         state_d = gr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == gr_pkg::B_IDLE);
    res_load    = (state_q == gr_pkg::B_DONE) && (!res_o.valid || res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gr_pkg::B_IDLE;
      res_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_o.valid <= 1'b1;
      end else if (res_o.ready) begin
        res_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gr_pkg::B_IDLE: begin
        // The first probe already lies one step from the viewer.
        px_q  <= $signed({2'b00, 22'(pos_x_i * 10'd640)})
               + gr_pkg::PrW'(job_i.dir_x);
        py_q  <= $signed({2'b00, 22'(pos_y_i * 10'd640)})
               + gr_pkg::PrW'(job_i.dir_y);
        ex_q  <= gr_pkg::PrW'(job_i.dir_x);
        ey_q  <= gr_pkg::PrW'(job_i.dir_y);
        n_q   <= 8'd1;
        col_q <= job_i.column;
      end
      gr_pkg::B_MARCH: begin
        if (outside) begin
          n_q   <= MaxN;
          hit_q <= 1'b0;
        end else if (wall) begin
          hit_q <= 1'b1;
        end else if (n_q == MaxN) begin
          hit_q <= 1'b0;
        end else begin
          px_q <= px_q + ex_q;
          py_q <= py_q + ey_q;
          n_q  <= n_q + 8'd1;
        end
      end
      gr_pkg::B_LOAD: begin
        quo_q   <= num;
        rem_q   <= '0;
        den_q   <= {1'b0, n_q, 1'b0};
        cnt_q   <= gr_pkg::DivCntW'(gr_pkg::NumW - 1);
        shade_q <= shade_d;
      end
      gr_pkg::B_DIV: begin
        if (rem_sub[gr_pkg::DenW]) begin
          rem_q <= rem_sh[gr_pkg::DenW-1:0];
          quo_q <= {quo_q[gr_pkg::NumW-2:0], 1'b0};
        end else begin
          rem_q <= rem_sub[gr_pkg::DenW-1:0];
          quo_q <= {quo_q[gr_pkg::NumW-2:0], 1'b1};
        end
        cnt_q <= cnt_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (res_load) begin
      res_o.column_out     <= col_q;
      res_o.distance_steps <= n_q;
      res_o.hit_wall       <= hit_q;
      res_o.ceiling_row    <= quo_q[6:0];
      res_o.floor_row      <= 8'(gr_pkg::ScreenHeight) - {1'b0, quo_q[6:0]};
      res_o.wall_shade     <= shade_q;
    end
  end

endmodule

// ===== rtl/grid_raycast_column_core.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column_core: one first-person ray per screen column
// Channel   Dir  Role
// column_i  in   screen column to cast
// result_o  out  step count, hit flag, ceiling/floor rows, shade
// cfg_*     in   map rows, viewer position and heading writes
// An item goes through direction lookup, a march of up to 160 steps, the
// bit-serial ceiling division and the result register.
// The march loop sets the rate; a two-entry queue lets lookup run ahead.
// Reset is asynchronous; it clears control state and the map and puts the viewer at the map centre, heading zero.
// A stalled result holds in the output register while the next march runs.
// ----------------------------------------------------------------------------
module grid_raycast_column_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gr_pkg::CfgDataW-1:0]   cfg_data_i,
  gr_column_if.sink                     column_i,
  gr_result_if.source                   result_o
);

  logic [63:0]  map_q [4];
  logic [11:0]  pos_x_q, pos_y_q, heading_q;
  logic         job_valid, job_ready, deq_valid, deq_ready;
  gr_pkg::job_t job, deq_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q[0]  <= '0;
      map_q[1]  <= '0;
      map_q[2]  <= '0;
      map_q[3]  <= '0;
      pos_x_q   <= 12'd2048;
      pos_y_q   <= 12'd2048;
      heading_q <= 12'd0;
    end else if (cfg_we_i) begin
      case (gr_pkg::cfg_reg_e'(cfg_idx_i))
        gr_pkg::REG_MAP0:    map_q[0]  <= cfg_data_i;
        gr_pkg::REG_MAP1:    map_q[1]  <= cfg_data_i;
        gr_pkg::REG_MAP2:    map_q[2]  <= cfg_data_i;
        gr_pkg::REG_MAP3:    map_q[3]  <= cfg_data_i;
        gr_pkg::REG_POS_X:   pos_x_q   <= cfg_data_i[11:0];
        gr_pkg::REG_POS_Y:   pos_y_q   <= cfg_data_i[11:0];
        gr_pkg::REG_HEADING: heading_q <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  gr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .heading_i   (heading_q),
    .in_valid_i  (column_i.valid),
    .in_ready_o  (column_i.ready),
    .in_column_i (column_i.column),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  gr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_job_i   (job),
    .pop_valid_o  (deq_valid),
    .pop_ready_i  (deq_ready),
    .pop_job_o    (deq_job)
  );

  gr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_i       ({map_q[3], map_q[2], map_q[1], map_q[0]}),
    .pos_x_i     (pos_x_q),
    .pos_y_i     (pos_y_q),
    .job_valid_i (deq_valid),
    .job_ready_o (deq_ready),
    .job_i       (deq_job),
    .res_o       (result_o)
  );

endmodule

// ===== bench/tb_grid_raycast_column_core.sv =====
// ----------------------------------------------------------------------------
// tb_grid_raycast_column_core: self-checking bench for the column ray caster
// Loads maps, positions and headings between phases, streams columns with
// random gaps on both sides and compares every result against a local
// fixed-point model of the march, the row split and the shade level.
// ----------------------------------------------------------------------------
module tb_grid_raycast_column_core;

  typedef struct packed {
    logic [7:0] column_out;
    logic [7:0] distance_steps;
    logic       hit_wall;
    logic [6:0] ceiling_row;
    logic [7:0] floor_row;
    logic [3:0] wall_shade;
  } ray_result_t;

  localparam int MapSpan = gr_pkg::MapSize * gr_pkg::CellUnits;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [gr_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [gr_pkg::CfgDataW-1:0] cfg_data_i = '0;

  gr_column_if column_ch ();
  gr_result_if result_ch ();

  grid_raycast_column_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .column_i(column_ch.sink), .result_o(result_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's registers.
  logic [63:0] map_words [4];
  logic [11:0] view_x, view_y, view_heading;

  logic [7:0]  column_queue [$];
  ray_result_t ray_expect [$];
  int          fail_count = 0;
  int          result_count = 0;
  int          hit_count = 0;
  bit          calm = 1'b0;
  longint      cycle_count = 0;

  function automatic int quadrant_sine(longint unsigned a);
    longint unsigned th, t2, s;
    th = (a * 64'd3373259426) / 64'd2048;
    t2 = (th * th) >> 30;
    s  = 64'd1073741824 - (t2 / 72);
    s  = 64'd1073741824 - (((t2 / 42) * s) >> 30);
    s  = 64'd1073741824 - (((t2 / 20) * s) >> 30);
    s  = 64'd1073741824 - (((t2 / 6) * s) >> 30);
    s  = (th * s) >> 30;
    return int'((s + 64'd32768) >> 16);
  endfunction

  function automatic int ray_sine(logic [11:0] a);
    logic [9:0] r;
    r = a[9:0];
    case (a[11:10])
      2'd0: return quadrant_sine(r);
      2'd1: return quadrant_sine(1024 - r);
      2'd2: return -quadrant_sine(r);
      default: return -quadrant_sine(1024 - r);
    endcase
  endfunction

  function automatic ray_result_t cast_ray(logic [7:0] col);
    ray_result_t res;
    logic [11:0] ang;
    int ex, ey, n, px, py, cx, cy, num, ceil_r;
    bit wall;
    logic [15:0] row_bits;
    ang = view_heading
        + 12'((int'(col) * gr_pkg::FovAngle) / gr_pkg::ScreenWidth)
        - 12'(gr_pkg::FovAngle / 2);
    ex = ray_sine(ang);
    ey = ray_sine(ang + 12'd1024);
    n = 0;
    wall = 1'b0;
    while (!wall && n < gr_pkg::MaxSteps) begin
      n++;
      px = int'(view_x) * gr_pkg::PosScale + ex * n;
      py = int'(view_y) * gr_pkg::PosScale + ey * n;
      if (px < 0 || py < 0 || px >= MapSpan || py >= MapSpan) begin
        n = gr_pkg::MaxSteps;
        break;
      end
      cx = px / gr_pkg::CellUnits;
      cy = py / gr_pkg::CellUnits;
      row_bits = map_words[cy / 4] >> ((cy % 4) * 16);
      wall = row_bits[cx];
    end
    num = gr_pkg::ScreenHeight * n - 20 * gr_pkg::ScreenHeight;
    ceil_r = (num <= 0) ? 0 : num / (2 * n);
    res.column_out = col;
    res.distance_steps = 8'(n);
    res.hit_wall = wall;
    res.ceiling_row = 7'(ceil_r);
    res.floor_row = 8'(gr_pkg::ScreenHeight - ceil_r);
    res.wall_shade = 4'd0;
    if (10 * n <= gr_pkg::MaxSteps) res.wall_shade = 4'd10;
    else begin
      for (int k = 9; k >= 1; k--) begin
        if (k * n < gr_pkg::MaxSteps) begin
          res.wall_shade = 4'(k);
          break;
        end
      end
    end
    return res;
  endfunction

  // Column driver with random idle bursts.
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_ch.valid <= 1'b0;
      column_ch.column <= '0;
    end else begin
      if (column_ch.valid && column_ch.ready) begin
        ray_expect.push_back(cast_ray(column_ch.column));
      end
      if (!column_ch.valid || column_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          column_ch.valid <= 1'b0;
        end else if (column_queue.size() > 0) begin
          column_ch.valid <= 1'b1;
          column_ch.column <= column_queue.pop_front();
          if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 8);
        end else begin
          column_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure bursts.
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        ray_result_t got, want;
        got = '{result_ch.column_out, result_ch.distance_steps, result_ch.hit_wall,
                result_ch.ceiling_row, result_ch.floor_row, result_ch.wall_shade};
        result_count++;
        if (got.hit_wall) hit_count++;
        if (ray_expect.size() == 0) begin
          $error("unexpected result for column %0d", got.column_out);
          fail_count++;
        end else begin
          want = ray_expect.pop_front();
          if (got.column_out != want.column_out) begin
            $error("column_out: expected %0d, got %0d", want.column_out, got.column_out);
            fail_count++;
          end
          if (got.distance_steps != want.distance_steps) begin
            $error("distance_steps: expected %0d, got %0d", want.distance_steps,
                   got.distance_steps);
            fail_count++;
          end
          if (got.hit_wall != want.hit_wall) begin
            $error("hit_wall: expected %0d, got %0d", want.hit_wall, got.hit_wall);
            fail_count++;
          end
          if (got.ceiling_row != want.ceiling_row) begin
            $error("ceiling_row: expected %0d, got %0d", want.ceiling_row, got.ceiling_row);
            fail_count++;
          end
          if (got.floor_row != want.floor_row) begin
            $error("floor_row: expected %0d, got %0d", want.floor_row, got.floor_row);
            fail_count++;
          end
          if (got.wall_shade != want.wall_shade) begin
            $error("wall_shade: expected %0d, got %0d", want.wall_shade, got.wall_shade);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 7);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Generous limit: 2025 items plus stalls and gaps.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(gr_pkg::cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      gr_pkg::REG_MAP0, gr_pkg::REG_MAP1, gr_pkg::REG_MAP2,
      gr_pkg::REG_MAP3: map_words[idx] = value;
      gr_pkg::REG_POS_X: view_x = value[11:0];
      gr_pkg::REG_POS_Y: view_y = value[11:0];
      default: view_heading = value[11:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (column_queue.size() == 0 && !column_ch.valid && ray_expect.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_map(int density);
    logic [63:0] m;
    for (int b = 0; b < 64; b++) m[b] = ($urandom_range(0, 99) < density);
    return m;
  endfunction

  task automatic setup(int density, logic [11:0] px, logic [11:0] py, logic [11:0] hd);
    write_reg(gr_pkg::REG_MAP0, rand_map(density));
    write_reg(gr_pkg::REG_MAP1, rand_map(density));
    write_reg(gr_pkg::REG_MAP2, rand_map(density));
    write_reg(gr_pkg::REG_MAP3, rand_map(density));
    write_reg(gr_pkg::REG_POS_X, px);
    write_reg(gr_pkg::REG_POS_Y, py);
    write_reg(gr_pkg::REG_HEADING, hd);
  endtask

  initial begin
    int density;
    for (int i = 0; i < 4; i++) map_words[i] = '0;
    view_x = 12'd2048;
    view_y = 12'd2048;
    view_heading = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty map after reset: every ray leaves the map at full depth.
    column_queue.push_back(8'd0);
    column_queue.push_back(8'd255);
    column_queue.push_back(8'd128);
    drain();

    // Directed: all-wall map gives a hit on the first step; corners and
    // every quadrant of heading, columns at the screen edges.
    setup(100, 12'd2048, 12'd2048, 12'd0);
    column_queue.push_back(8'd0);
    column_queue.push_back(8'd255);
    drain();
    // Distant walls: walls only on the first and last map rows, seen from the center.
    write_reg(gr_pkg::REG_MAP0, 64'hFFFF);
    write_reg(gr_pkg::REG_MAP1, '0);
    write_reg(gr_pkg::REG_MAP2, '0);
    write_reg(gr_pkg::REG_MAP3, 64'hFFFF_0000_0000_0000);
    for (int q = 0; q < 4; q++) begin
      write_reg(gr_pkg::REG_HEADING, 12'(q * 1024));
      column_queue.push_back(8'd0);
      column_queue.push_back(8'd128);
      column_queue.push_back(8'd255);
      column_queue.push_back(8'(q * 37 + 5));
      drain();
    end
    setup(100, 12'd0, 12'd0, 12'd4095);
    column_queue.push_back(8'd85);
    column_queue.push_back(8'd170);
    drain();
    setup(0, 12'd4095, 12'd4095, 12'd2048);
    column_queue.push_back(8'd1);
    column_queue.push_back(8'd254);
    drain();

    // Random phases; the last one has no idling.
    for (int ph = 0; ph < 20; ph++) begin
      density = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 100 : $urandom_range(5, 40);
      if (ph == 19) calm = 1'b1;
      setup(density, 12'($urandom), 12'($urandom), 12'($urandom));
      repeat (100) column_queue.push_back(8'($urandom));
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("Cast %0d columns over many maps, positions and headings, %0d wall hits.",
             result_count, hit_count);
    if (fail_count == 0 && ray_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gr_pkg.sv
rtl/gr_if.sv
rtl/gr_front.sv
rtl/gr_queue.sv
rtl/gr_back.sv
rtl/grid_raycast_column_core.sv
bench/tb_grid_raycast_column_core.sv
